[rtl/ldf_pkg.sv]
// ---------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants for the length-prefixed deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

  // Largest accepted message payload, in bytes
  localparam int MaxMsgBytes = 256;
  // Payload byte counter width; holds MaxMsgBytes itself
  localparam int CntW        = $clog2(MaxMsgBytes + 1);
  // Length prefix: four bytes, little-endian
  localparam int HdrBytes    = 4;
  localparam int HdrCntW     = $clog2(HdrBytes);
  localparam int LenW        = 8 * HdrBytes;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhPayload = 3'b010,
    PhDiscard = 3'b100
  } phase_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindDesync  = 1'b1
  } kind_e;

  typedef struct packed {
    phase_e              phase;
    logic [HdrCntW-1:0]  hdr_cnt;
    logic [LenW-1:0]     len;
    logic [CntW-1:0]     rcvd;
  } ldf_state_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       eom;
  } ldf_result_t;

  localparam ldf_state_t StateCleared = '{
    phase:   PhHeader,
    hdr_cnt: '0,
    len:     '0,
    rcvd:    '0
  };

endpackage

`default_nettype wire

[rtl/ldf_step.sv]
// ---------------------------------------------------------------------------
// ldf_step
// Next-state and result logic for one stream byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_step (
  input  ldf_pkg::ldf_state_t  cur_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 chunk_end_i,
  output ldf_pkg::ldf_state_t  nxt_o,
  output ldf_pkg::ldf_result_t res_o
);

  logic [ldf_pkg::LenW-1:0] len_new;
  logic [ldf_pkg::CntW-1:0] rcvd_inc;
  logic                     eom;

  // Header byte lands in its little-endian slot
  always_comb begin
    len_new = cur_i.len;
    len_new[{cur_i.hdr_cnt, 3'b000} +: 8] = cur_i.len[{cur_i.hdr_cnt, 3'b000} +: 8] | data_byte_i;
  end

  assign rcvd_inc = cur_i.rcvd + ldf_pkg::CntW'(1);
  // Valid length never exceeds MaxMsgBytes, so the low bits carry it
  assign eom      = (rcvd_inc == cur_i.len[ldf_pkg::CntW-1:0]);

  always_comb begin
    nxt_o              = cur_i;
    res_o              = '0;
    res_o.kind         = ldf_pkg::KindPayload;
    case (cur_i.phase)
      ldf_pkg::PhDiscard: begin
        if (chunk_end_i) begin
          nxt_o = ldf_pkg::StateCleared;
        end
      end
      ldf_pkg::PhPayload: begin
        res_o.valid        = 1'b1;
        res_o.payload_byte = data_byte_i;
        res_o.byte_index   = 8'(cur_i.rcvd);
        res_o.eom          = eom;
        if (eom) begin
          nxt_o = ldf_pkg::StateCleared;
        end else begin
          nxt_o.rcvd = rcvd_inc;
        end
      end
      default: begin
        // header collection; unused codes fall in here too
        nxt_o.phase = ldf_pkg::PhHeader;
        if (cur_i.hdr_cnt != ldf_pkg::HdrCntW'(ldf_pkg::HdrBytes - 1)) begin
          nxt_o.len     = len_new;
          nxt_o.hdr_cnt = cur_i.hdr_cnt + ldf_pkg::HdrCntW'(1);
        end else if ((len_new == '0) ||
                     (len_new > ldf_pkg::LenW'(ldf_pkg::MaxMsgBytes))) begin
          res_o.valid = 1'b1;
          res_o.kind  = ldf_pkg::KindDesync;
          nxt_o       = ldf_pkg::StateCleared;
          if (!chunk_end_i) begin
            nxt_o.phase = ldf_pkg::PhDiscard;
          end
        end else begin
          nxt_o.phase   = ldf_pkg::PhPayload;
          nxt_o.hdr_cnt = '0;
          nxt_o.len     = len_new;
          nxt_o.rcvd    = '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/length_prefixed_deframer_core.sv]
// ---------------------------------------------------------------------------
// length_prefixed_deframer_core
// Splits a byte stream into messages framed by a 4-byte little-endian
// length; forwards payload words with index and end-of-message mark, and
// reports a desync on a zero or oversized length.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------
//  in      | sink      | in_valid_i/in_stall_o | data_byte_i, chunk_end_i
//  out     | source    | out_valid_o/out_stall_i | kind_o, payload_byte_o,
//          |           |                       | byte_index_o, end_of_message_o
//
//  One word per cycle while out is not stalled. Words pass an input register,
//  then the next-state logic writes the state and the output register.
//  The deframer state lives in a single register and updates in the same
//  cycle as the output register, so consecutive words chain without bubbles.
//  rst_ni (async, active low) returns to header collection with nothing held.
//  A stall on out backs up through the input register to in_stall_o; words
//  that produce no result (header, discard) still wait for that slot.
// ---------------------------------------------------------------------------
`default_nettype none

module length_prefixed_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_end_i,

  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] byte_index_o,
  output logic       end_of_message_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // deframer state
  ldf_pkg::ldf_state_t  state_q, state_d;
  ldf_pkg::ldf_result_t res;

  // output register
  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_byte_q;
  logic [7:0] out_idx_q;
  logic       out_eom_q;

  logic adv;   // output slot free this cycle
  logic load;  // input register takes a new word

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !adv;
  assign load       = !in_stall_o;

  ldf_step u_step (
    .cur_i       (state_q),
    .data_byte_i (in_byte_q),
    .chunk_end_i (in_end_q),
    .nxt_o       (state_d),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ldf_pkg::StateCleared;
    end else begin
      if (load) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q && res.valid;
      end
      // state moves only when the held word is consumed
      if (in_valid_q && adv) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= chunk_end_i;
    end
    if (adv) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.payload_byte;
      out_idx_q  <= res.byte_index;
      out_eom_q  <= res.eom;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign payload_byte_o   = out_byte_q;
  assign byte_index_o     = out_idx_q;
  assign end_of_message_o = out_eom_q;

endmodule

`default_nettype wire

[rtl/ldf_checker.sv]
// ---------------------------------------------------------------------------
// ldf_checker
// Port-level checks for the length-prefixed deframer.
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       kind_o,
  input logic [7:0] payload_byte_o,
  input logic [7:0] byte_index_o,
  input logic       end_of_message_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(payload_byte_o) && $stable(byte_index_o) && $stable(end_of_message_o))
    else $error("result changed under stall");

  // valid drops only after the word was taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without being taken");

  // desync words carry zero fields
  a_desync_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == ldf_pkg::KindDesync) |->
    (payload_byte_o == 8'd0) && (byte_index_o == 8'd0) && !end_of_message_o)
    else $error("desync word with nonzero fields");

  // a fresh result traces back to an accepted input word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted input");

endmodule

bind length_prefixed_deframer_core ldf_checker u_ldf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .payload_byte_o   (payload_byte_o),
  .byte_index_o     (byte_index_o),
  .end_of_message_o (end_of_message_o)
);

`default_nettype wire

[dv/length_prefixed_deframer_core_tb.sv]
// ---------------------------------------------------------------------------
// length_prefixed_deframer_core_tb
// Self-checking bench for the deframer: drives framed byte streams (good
// messages, bad lengths, chunk ends, line noise), predicts every output
// word in lockstep with accepted input words, and checks each one in order.
// ---------------------------------------------------------------------------
`default_nettype none

module length_prefixed_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;  // cycles without any handshake
  localparam int LongHold      = 300;   // receiver hold-off for the backpressure test
  localparam int DrainCycles   = 8;     // settle time after the last expected word
  localparam int MaxReports    = 10;

  // One expected output word
  typedef struct packed {
    ldf_pkg::kind_e kind;
    logic [7:0]     data;
    logic [7:0]     pos;
    logic           eom;
  } deframed_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       chunk_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] byte_index_o;
  logic       end_of_message_o;

  length_prefixed_deframer_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .chunk_end_i      (chunk_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .end_of_message_o (end_of_message_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // Shared bench state
  // -------------------------------------------------------------------------
  int unsigned send_idle_pct = 0;   // chance per cycle that the sender idles
  int unsigned stall_pct     = 0;   // chance per cycle that the receiver stalls
  int unsigned words_sent    = 0;
  int unsigned errors        = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_requests = 0;   // bumped by a test, served by the receiver
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  deframed_word_t deframed_q[$];

  // Predictor state: mirrors the deframer's own registers
  ldf_pkg::phase_e rx_phase  = ldf_pkg::PhHeader;
  logic [1:0]      hdr_seen  = '0;   // length bytes gathered, wraps after four
  logic [31:0]     msg_len   = '0;   // length being gathered or in force
  logic [8:0]      pay_count = '0;   // payload bytes delivered so far

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic void clear_frame();
    rx_phase  = ldf_pkg::PhHeader;
    hdr_seen  = '0;
    msg_len   = '0;
    pay_count = '0;
  endfunction

  // Advance the model by one accepted input word; queue any output word.
  function automatic void deframe_byte(input logic [7:0] b, input logic ce);
    deframed_word_t res;
    case (rx_phase)
      // Drop everything up to the end of the chunk, then resync.
      ldf_pkg::PhDiscard: begin
        if (ce) clear_frame();
      end
      ldf_pkg::PhPayload: begin
        res.kind = ldf_pkg::KindPayload;
        res.data = b;
        res.pos  = pay_count[7:0];
        res.eom  = ({23'd0, pay_count} + 32'd1) >= msg_len;
        deframed_q = {deframed_q, res};
        if (res.eom) clear_frame();
        else pay_count = pay_count + 9'd1;
      end
      // Header collection; any stray phase value is treated the same.
      // Chunk end does not clear a partial header here; it carries over.
      default: begin
        rx_phase = ldf_pkg::PhHeader;
        msg_len  = msg_len | ({24'd0, b} << (8 * hdr_seen));
        hdr_seen = hdr_seen + 2'd1;
        if (hdr_seen == 2'd0) begin
          if (msg_len == 32'd0 || msg_len > ldf_pkg::MaxMsgBytes) begin
            // Bad length: one desync word, then drop to end of chunk
            // unless this very byte already ends it.
            res = '{kind: ldf_pkg::KindDesync, data: 8'h00, pos: 8'h00, eom: 1'b0};
            deframed_q = {deframed_q, res};
            clear_frame();
            if (!ce) rx_phase = ldf_pkg::PhDiscard;
          end else begin
            rx_phase  = ldf_pkg::PhPayload;
            pay_count = '0;
          end
        end
      end
    endcase
  endfunction

  // Input monitor: every accepted word goes through the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) deframe_byte(data_byte_i, chunk_end_i);
  end

  // -------------------------------------------------------------------------
  // Output checker
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    deframed_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (deframed_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected output word kind=%0d byte=%02h idx=%0d eom=%0d",
                   $realtime, kind_o, payload_byte_o, byte_index_o, end_of_message_o);
      end else begin
        want = deframed_q.pop_front();
        if (kind_o !== want.kind || payload_byte_o !== want.data ||
            byte_index_o !== want.pos || end_of_message_o !== want.eom) begin
          errors++;
          if (errors <= MaxReports)
            $display({"%0t: mismatch exp kind=%0d byte=%02h idx=%0d eom=%0d,",
                      " got kind=%0d byte=%02h idx=%0d eom=%0d"},
                     $realtime, want.kind, want.data, want.pos, want.eom,
                     kind_o, payload_byte_o, byte_index_o, end_of_message_o);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LongHold;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: too long without any handshake means a hang
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Sender
  // -------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [7:0] b, input logic ce);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    chunk_end_i <= ce;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Length prefix, little-endian, with a chosen chunk end per byte
  task automatic send_header(input logic [31:0] len, input logic [3:0] ce_mask);
    for (int i = 0; i < 4; i++) send_word(len[8*i +: 8], ce_mask[i]);
  endtask

  // Well-formed message, random content and chunk boundaries
  task automatic send_frame(input int unsigned len);
    send_header(len, {$urandom_range(7) == 0, $urandom_range(7) == 0,
                      $urandom_range(7) == 0, $urandom_range(7) == 0});
    repeat (len) send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // Bad length, then junk up to the chunk end unless the header closed it
  task automatic send_bad_frame();
    logic [31:0] len;
    logic        ce_last;
    case ($urandom_range(3))
      0: len = 32'd0;
      1: len = ldf_pkg::MaxMsgBytes + 1;
      2: len = $urandom_range(32'hFFFF, ldf_pkg::MaxMsgBytes + 1);
      default: len = $urandom | 32'h0100_0000;
    endcase
    ce_last = ($urandom_range(3) == 0);
    send_header(len, {ce_last, $urandom_range(7) == 0,
                      $urandom_range(7) == 0, $urandom_range(7) == 0});
    if (!ce_last) begin
      repeat ($urandom_range(4)) send_word(8'($urandom_range(255)), 1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Mostly framed traffic; bad lengths and raw noise mixed in
  task automatic run_traffic(input int unsigned n_words, input int unsigned idle_pct,
                             input int unsigned stall_p);
    int unsigned stop_at;
    int unsigned pick;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    stop_at       = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(24) == 0) send_frame($urandom_range(ldf_pkg::MaxMsgBytes, 200));
        else send_frame($urandom_range(12, 1));
      end else if (pick < 85) begin
        send_bad_frame();
      end else begin
        repeat ($urandom_range(6, 1))
          send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_header(32'd1, 4'b0000);           // shortest message
    send_word(8'hFF, 1'b1);                // chunk end in payload is ignored
    send_header(32'd0, 4'b1000);           // zero length closing the chunk
    send_header(ldf_pkg::MaxMsgBytes + 1, 4'b0000); // one over max, chunk still open
    send_word(8'hFF, 1'b0);                // discarded
    send_word(8'h00, 1'b1);                // discarded, chunk closes
    send_header(32'hFFFF_FFFF, 4'b1000);   // all-ones length
    send_header(32'd2, 4'b0010);           // chunk end mid-header carries over
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
  endtask

  // Largest legal message: index runs 0..255
  task automatic test_max_length();
    send_idle_pct = 0;
    stall_pct     = 20;
    send_header(ldf_pkg::MaxMsgBytes, 4'b0000);
    repeat (ldf_pkg::MaxMsgBytes)
      send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
  endtask

  task automatic test_random_idle_mix();
    run_traffic(300, 0, 0);
    run_traffic(300, 80, 0);
    run_traffic(300, 0, 80);
    run_traffic(300, 38, 38);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    hold_requests++;
    run_traffic(150, 0, 0);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    chunk_end_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_max_length();
    test_random_idle_mix();
    test_backpressure();

    // Drain: let every predicted word come out, then DrainCycles more.
    // The first wait lets the monitor queue the last accepted word.
    in_valid_i <= 1'b0;
    stall_pct  = 30;
    @(posedge clk_i);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (deframed_q.size() != 0) begin
      if (errors < MaxReports) $display("%0d expected words never arrived", deframed_q.size());
      errors += deframed_q.size();
    end
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/ldf_pkg.sv
rtl/ldf_step.sv
rtl/length_prefixed_deframer_core.sv
rtl/ldf_checker.sv
dv/length_prefixed_deframer_core_tb.sv
